@@ rtl/kbs_pkg.sv @@
package kbs_pkg;

  // field widths of the channels
  localparam int CHAR_W  = 8;
  localparam int ENTRY_W = 8;
  localparam int POS_W   = 5;
  localparam int TS_W    = 9;

  // register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register indexes (byte address / 4)
  localparam logic REG_TABLE_SIZE = 1'b0;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

@@ rtl/kbs_in_if.sv @@
interface kbs_in_if;
  import kbs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [ENTRY_W-1:0]    entry_index;
  logic [POS_W-1:0]      char_position;
  logic [CHAR_W-1:0]     char_value;
  logic                  last_char;

  modport source (
    output valid, kind, entry_index, char_position, char_value, last_char,
    input  ready
  );

  modport sink (
    input  valid, kind, entry_index, char_position, char_value, last_char,
    output ready
  );
endinterface

@@ rtl/kbs_out_if.sv @@
interface kbs_out_if;
  import kbs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [ENTRY_W-1:0]    match_index;

  modport source (
    output valid, found, match_index,
    input  ready
  );

  modport sink (
    input  valid, found, match_index,
    output ready
  );
endinterface

@@ rtl/keyword_binary_search_top.sv @@
// Keyword table search.
// in_ch takes words of two kinds. A load word writes one byte of a stored key
// (entry_index, char_position); a zero byte ends a key. A query word appends
// one identifier character (A..Z folded to lower case, characters past the
// first KEY_CHARS-1 dropped). A query word with last_char set starts a binary
// search over the first table_size entries in strcmp byte order; out_ch then
// carries one word with found and match_index (zero when not found).
// Load words and non-final query words give no result. A final query word
// makes at most ceil(log2(n+1)) probes, n = table_size capped at MAX_ENTRIES,
// each comparing up to KEY_CHARS bytes, before the result is loaded into the
// output register; one byte comparator and one key memory read port do the
// work, one byte per cycle. in_ch.ready is low for the whole search. The
// result waits in the output register; while it waits, further load and
// query words are taken, and only the next search stalls at its end until the
// receiver takes the waiting word. table_size is set over the APB port at
// address 0; the user is to set it only while the block is idle, which the
// block itself does not enforce. Reset (rst_n low, synchronous) clears
// table_size, the identifier length and the output valid; key memory
// contents are kept and need loading.
module keyword_binary_search_top #(
  parameter int MAX_ENTRIES = 256,
  parameter int KEY_CHARS   = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  kbs_in_if.sink                       in_ch,
  kbs_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kbs_pkg::PADDR_W-1:0]  paddr,
  input  logic [kbs_pkg::PDATA_W-1:0]  pwdata,
  output logic [kbs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import kbs_pkg::*;

  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int EW    = $clog2(MAX_ENTRIES);
  localparam int KW    = $clog2(KEY_CHARS);
  localparam int DEPTH = MAX_ENTRIES * KEY_CHARS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_START  = 5'b00010,
    ST_PROBE  = 5'b00100,
    ST_CMP    = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [TS_W-1:0]     tsize_r, tsize_nxt;
  logic [KW-1:0]       qlen_r, qlen_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hb_r, hb_nxt;
  logic [EW-1:0]       mid_r, mid_nxt;
  logic [KW-1:0]       pos_r, pos_nxt;
  logic                hit_r, hit_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic                ofound_r, ofound_nxt;
  logic [ENTRY_W-1:0]  oidx_r, oidx_nxt;

  logic [CHAR_W-1:0]   qbuf_r [KEY_CHARS];
  logic [CHAR_W-1:0]   key_mem [DEPTH];
  logic [CHAR_W-1:0]   rd_data_r;

  logic                in_acc;
  logic                cfg_wr;
  logic                load_wr;
  logic                qry_wr;
  logic [CHAR_W-1:0]   fold_ch;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [EW-1:0]       rd_entry;
  logic [KW-1:0]       rd_pos;
  logic [CW-1:0]       n_used;
  logic [CW:0]         mid_sum;
  logic [EW-1:0]       mid_calc;
  logic [CHAR_W-1:0]   q_ch;
  logic                q_empty;

  // handshake and register port
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign pready      = 1'b1;
  assign prdata      = (paddr[PADDR_W-1:2] == REG_TABLE_SIZE)
                       ? PDATA_W'(tsize_r) : '0;

  assign out_ch.valid       = ovalid_r;
  assign out_ch.found       = ofound_r;
  assign out_ch.match_index = oidx_r;

  // load and query word decode
  assign load_wr = in_acc && (in_ch.kind == KIND_LOAD)
                   && (32'(in_ch.entry_index) < MAX_ENTRIES)
                   && (32'(in_ch.char_position) < KEY_CHARS);
  assign qry_wr  = in_acc && (in_ch.kind == KIND_QUERY)
                   && (32'(qlen_r) < KEY_CHARS - 1);
  assign fold_ch = (in_ch.char_value >= 8'h41 && in_ch.char_value <= 8'h5a)
                   ? in_ch.char_value + 8'h20 : in_ch.char_value;
  assign wr_addr = AW'(32'(in_ch.entry_index) * KEY_CHARS
                       + 32'(in_ch.char_position));

  // saturated entry count and probe midpoint
  assign n_used   = (32'(tsize_r) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(tsize_r);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hb_r} - (CW + 1)'(1);
  assign mid_calc = EW'(mid_sum >> 1);
  assign q_empty  = (qlen_r == '0) || (qbuf_r[0] == '0);

  // query byte under comparison; bytes past the identifier read as zero
  assign q_ch = (pos_r < qlen_r) ? qbuf_r[pos_r] : '0;

  // key memory read address: first byte on a probe, next byte while comparing
  always_comb begin
    if (state_r == ST_PROBE) begin
      rd_entry = mid_calc;
      rd_pos   = '0;
    end else begin
      rd_entry = mid_r;
      rd_pos   = (pos_r == KW'(KEY_CHARS - 1)) ? pos_r : pos_r + KW'(1);
    end
  end
  assign rd_addr = AW'(32'(rd_entry) * KEY_CHARS + 32'(rd_pos));

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    tsize_nxt  = tsize_r;
    qlen_nxt   = qlen_r;
    lo_nxt     = lo_r;
    hb_nxt     = hb_r;
    mid_nxt    = mid_r;
    pos_nxt    = pos_r;
    hit_nxt    = hit_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ofound_nxt = ofound_r;
    oidx_nxt   = oidx_r;

    if (cfg_wr && paddr[PADDR_W-1:2] == REG_TABLE_SIZE) begin
      tsize_nxt = pwdata[TS_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (qry_wr) begin
          qlen_nxt = qlen_r + KW'(1);
        end
        if (in_acc && in_ch.kind == KIND_QUERY && in_ch.last_char) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        lo_nxt    = '0;
        hb_nxt    = q_empty ? '0 : n_used;
        hit_nxt   = 1'b0;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (lo_r < hb_r) begin
          mid_nxt   = mid_calc;
          pos_nxt   = '0;
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_CMP: begin
        // one byte a cycle: rd_data_r holds key byte pos_r of entry mid_r
        if (q_ch != rd_data_r) begin
          if (q_ch < rd_data_r) begin
            hb_nxt = CW'(mid_r);
          end else begin
            lo_nxt = CW'(mid_r) + CW'(1);
          end
          state_nxt = ST_PROBE;
        end else if (q_ch == '0 || pos_r == KW'(KEY_CHARS - 1)) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          pos_nxt = pos_r + KW'(1);
        end
      end
      ST_RESULT: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          ofound_nxt = hit_r;
          oidx_nxt   = hit_r ? ENTRY_W'(mid_r) : '0;
          qlen_nxt   = '0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tsize_r  <= '0;
      qlen_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tsize_r  <= tsize_nxt;
      qlen_r   <= qlen_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // search and result payload
  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hb_r     <= hb_nxt;
    mid_r    <= mid_nxt;
    pos_r    <= pos_nxt;
    hit_r    <= hit_nxt;
    ofound_r <= ofound_nxt;
    oidx_r   <= oidx_nxt;
  end

  // identifier buffer
  always_ff @(posedge clk) begin
    if (qry_wr) begin
      qbuf_r[qlen_r] <= fold_ch;
    end
  end

  // key memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (load_wr) begin
      key_mem[wr_addr] <= in_ch.char_value;
    end
    rd_data_r <= key_mem[rd_addr];
  end

endmodule

@@ rtl/kbs_chk.sv @@
module kbs_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_kind,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_found,
  input logic [kbs_pkg::ENTRY_W-1:0]  out_index
);
  import kbs_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_index))
    else $error("result word changed while stalled");

  // not found always reports index zero
  a_miss_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_index == '0)
    else $error("nonzero index on a miss");

  // a final query word starts a search that blocks the input
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_QUERY && in_last |=> !in_ready)
    else $error("input ready right after a final query word");

  // a new result only comes out of a search
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_ready) == 1'b0)
    else $error("result word without a preceding search");

endmodule

bind keyword_binary_search_top kbs_chk u_kbs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .in_last   (in_ch.last_char),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_found (out_ch.found),
  .out_index (out_ch.match_index)
);

@@ sim/keyword_binary_search_top_tb.sv @@
module keyword_binary_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kbs_pkg::*;

  localparam int MAX_ENTRIES     = 256;
  localparam int KEY_CHARS       = 32;
  localparam int IDLE_PCT        = 7;
  localparam int RANDOM_WORDS    = 450;
  localparam int PHASE_WORDS     = 70;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DRAIN_CYCLES    = 400;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int CYCLE_LIMIT     = 4000000;
  localparam logic [PADDR_W-1:0] TABLE_SIZE_ADDR = PADDR_W'(REG_TABLE_SIZE) << 2;

  typedef struct packed {
    logic               kind;
    logic [ENTRY_W-1:0] entry;
    logic [POS_W-1:0]   pos;
    logic [CHAR_W-1:0]  ch;
    logic               last;
  } kbs_word_t;

  typedef struct packed {
    logic               found;
    logic [ENTRY_W-1:0] index;
  } lookup_t;

  typedef logic [CHAR_W-1:0] char_q_t [$];

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  kbs_in_if  in_ch ();
  kbs_out_if out_ch ();

  keyword_binary_search_top #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_CHARS   (KEY_CHARS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the keyword memory and the identifier being collected
  logic [CHAR_W-1:0] key_bytes [MAX_ENTRIES][KEY_CHARS];
  bit                key_known [MAX_ENTRIES][KEY_CHARS];
  logic [CHAR_W-1:0] ident [KEY_CHARS];
  int                ident_len;
  logic [TS_W-1:0]   table_size_r;
  string             entry_word [MAX_ENTRIES];

  lookup_t lookups_due [$];

  int src_idle_pct  = IDLE_PCT;
  int sink_idle_pct = IDLE_PCT;
  int hold_off_left = 0;
  int fails         = 0;
  int cycle_count   = 0;
  int words_sent    = 0;
  int load_words    = 0;
  int query_words   = 0;
  int searches      = 0;
  int hits          = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // strcmp order of the current identifier against one stored key
  function automatic int order_vs_entry(int e);
    logic [CHAR_W-1:0] q;
    logic [CHAR_W-1:0] k;
    for (int i = 0; i < KEY_CHARS; i++) begin
      q = (i < ident_len) ? ident[i] : 8'h00;
      k = key_bytes[e][i];
      if (q != k) return (q < k) ? -1 : 1;
      if (q == 8'h00) return 0;
    end
    return 0;
  endfunction

  function automatic lookup_t search_keywords();
    lookup_t r;
    int n;
    int lo;
    int hi;
    int mid;
    int d;
    r = '0;
    n = (table_size_r > MAX_ENTRIES) ? MAX_ENTRIES : int'(table_size_r);
    // empty identifier or empty table never probes
    if (ident_len > 0 && ident[0] != 8'h00 && n > 0) begin
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        d = order_vs_entry(mid);
        if (d == 0) begin
          r.found = 1'b1;
          r.index = ENTRY_W'(mid);
          break;
        end
        if (d < 0) hi = mid - 1;
        else lo = mid + 1;
      end
    end
    return r;
  endfunction

  // update the shadow state with one accepted word
  function automatic void absorb_word(kbs_word_t w);
    logic [CHAR_W-1:0] c;
    lookup_t r;
    if (w.kind == KIND_LOAD) begin
      key_bytes[w.entry][w.pos] = w.ch;
      key_known[w.entry][w.pos] = 1'b1;
      load_words++;
    end else begin
      c = w.ch;
      query_words++;
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      // characters past the buffer are dropped
      if (ident_len < KEY_CHARS - 1) begin
        ident[ident_len] = c;
        ident_len++;
      end
      if (w.last) begin
        r = search_keywords();
        lookups_due.push_back(r);
        searches++;
        if (r.found) hits++;
        foreach (ident[i]) ident[i] = 8'h00;
        ident_len = 0;
      end
    end
  endfunction

  // a noise write must leave the key terminated by written bytes
  function automatic bit keeps_closed(int e, int p, logic [CHAR_W-1:0] v);
    logic [CHAR_W-1:0] b;
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (i != p && !key_known[e][i]) return 1'b0;
      b = (i == p) ? v : key_bytes[e][i];
      if (b == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic kbs_word_t load_item(int e, int p, logic [CHAR_W-1:0] c);
    kbs_word_t w;
    w.kind  = KIND_LOAD;
    w.entry = ENTRY_W'(e);
    w.pos   = POS_W'(p);
    w.ch    = c;
    w.last  = 1'($urandom);
    return w;
  endfunction

  function automatic kbs_word_t query_item(logic [CHAR_W-1:0] c, bit last);
    kbs_word_t w;
    w.kind  = KIND_QUERY;
    w.entry = ENTRY_W'($urandom);
    w.pos   = POS_W'($urandom);
    w.ch    = c;
    w.last  = last;
    return w;
  endfunction

  function automatic char_q_t to_chars(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic char_q_t mix_case(char_q_t q);
    foreach (q[i])
      if (q[i] >= "a" && q[i] <= "z" && $urandom_range(0, 1) == 1) q[i] = q[i] - 8'd32;
    return q;
  endfunction

  function automatic logic [CHAR_W-1:0] random_letter();
    return 8'(8'h61 + $urandom_range(0, 25));
  endfunction

  // mostly letters, some digits and underscores
  function automatic string random_word(int maxlen);
    string s;
    int k;
    logic [CHAR_W-1:0] c;
    s = "";
    repeat ($urandom_range(1, maxlen)) begin
      k = $urandom_range(0, 10);
      if ($urandom_range(0, 9) < 8) c = random_letter();
      else c = (k == 10) ? 8'h5F : 8'(8'h30 + k);
      s = $sformatf("%s%c", s, c);
    end
    return s;
  endfunction

  // identifier built around the keys in use: hits, near misses and junk
  function automatic char_q_t random_ident();
    char_q_t q;
    int eff;
    int r;
    eff = (table_size_r > MAX_ENTRIES) ? MAX_ENTRIES : int'(table_size_r);
    q = to_chars(entry_word[$urandom_range(0, (eff == 0) ? MAX_ENTRIES - 1 : eff - 1)]);
    r = $urandom_range(0, 99);
    if (r < 50) begin
      q = mix_case(q);
    end else if (r < 60) begin
      if (q.size() > 1) void'(q.pop_back());
      else q.push_back(random_letter());
    end else if (r < 70) begin
      q.push_back(random_letter());
    end else if (r < 78) begin
      q[$urandom_range(0, q.size() - 1)] = random_letter();
    end else if (r < 85) begin
      q.push_back(8'h00);
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
    end else if (r < 93) begin
      q.delete();
      repeat ($urandom_range(1, 8)) q.push_back(8'($urandom));
    end else if (r < 97) begin
      repeat ($urandom_range(KEY_CHARS - q.size(), KEY_CHARS + 8)) q.push_back(random_letter());
    end else begin
      q = '{8'h00};
    end
    return q;
  endfunction

  // send one word on the input channel, waiting for the handshake
  task automatic send_word(kbs_word_t w);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= w.kind;
    in_ch.entry_index   <= w.entry;
    in_ch.char_position <= w.pos;
    in_ch.char_value    <= w.ch;
    in_ch.last_char     <= w.last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    absorb_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_ident(char_q_t q);
    foreach (q[i]) send_word(query_item(q[i], i == q.size() - 1));
  endtask

  task automatic load_word(int e, string w);
    for (int i = 0; i < w.len(); i++) send_word(load_item(e, i, w[i]));
    if (w.len() < KEY_CHARS) send_word(load_item(e, w.len(), 8'h00));
    entry_word[e] = w;
  endtask

  // distinct random keys, loaded into entries 0..n-1 in ascending order
  task automatic load_sorted_keys(int n, int maxlen);
    bit picked [string];
    int e;
    while (picked.num() < n) picked[random_word(maxlen)] = 1'b1;
    e = 0;
    foreach (picked[w]) begin
      load_word(e, w);
      e++;
    end
  endtask

  task automatic noise_load();
    int e;
    int p;
    int r;
    logic [CHAR_W-1:0] v;
    do begin
      e = $urandom_range(0, MAX_ENTRIES - 1);
      p = $urandom_range(0, KEY_CHARS - 1);
      r = $urandom_range(0, 99);
      v = (r < 40) ? 8'($urandom) : (r < 70) ? random_letter() : 8'h00;
    end while (!keeps_closed(e, p, v));
    send_word(load_item(e, p, v));
  endtask

  // drop valid and wait until every search result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (lookups_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write of table_size followed by a read back
  task automatic set_table_size(int v);
    // no word offered on the input during the register access
    in_ch.valid <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TABLE_SIZE_ADDR;
    pwdata  <= PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    table_size_r = TS_W'(v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== PDATA_W'(table_size_r)) begin
      $error("table_size: expected %0d, got %0d", table_size_r, prdata);
      fails++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // loads a small hand-made table; with size zero nothing can be found
  task automatic test_empty_table();
    string long_key;
    string top_key;
    long_key = "long";
    repeat (KEY_CHARS - 5) long_key = {long_key, "x"};
    top_key = "";
    repeat (KEY_CHARS) top_key = {top_key, "z"};
    set_table_size(0);
    load_word(0, "a");
    load_word(1, "break");
    load_word(2, "case");
    load_word(3, long_key);
    load_word(4, "while");
    load_word(5, top_key);
    send_ident(to_chars("break"));
    send_ident(to_chars("a"));
    settle();
  endtask

  task automatic test_directed_cases();
    char_q_t q;
    set_table_size(6);
    send_ident(to_chars("BrEaK"));
    send_ident(to_chars("a"));
    send_ident(to_chars("whilE"));
    send_ident(to_chars("cas"));
    // empty identifier, also when the first character is zero
    send_ident('{8'h00});
    q = to_chars("ab");
    q.push_front(8'h00);
    send_ident(q);
    // a zero ends the identifier early
    q = to_chars("case");
    q.push_back(8'h00);
    q.push_back("z");
    send_ident(q);
    // over-long identifier: only the first 31 characters count
    send_ident(to_chars({entry_word[3], "qqqqqqqqq"}));
    // against the key that has no terminator
    q.delete();
    repeat (KEY_CHARS - 1) q.push_back("Z");
    send_ident(q);
    // bytes just outside the folded range, and one with the top bit set
    q = to_chars("@[");
    q.push_front(8'hC1);
    send_ident(q);
    settle();
  endtask

  // all entries in use, then sizes above the table depth
  task automatic test_full_table();
    load_sorted_keys(MAX_ENTRIES, 3);
    set_table_size(MAX_ENTRIES);
    send_ident(to_chars(entry_word[0]));
    send_ident(mix_case(to_chars(entry_word[MAX_ENTRIES - 1])));
    send_ident(to_chars(entry_word[MAX_ENTRIES / 2]));
    send_ident(to_chars("zzzz"));
    settle();
    set_table_size(300);
    send_ident(to_chars(entry_word[MAX_ENTRIES - 1]));
    send_ident(to_chars(entry_word[$urandom_range(0, MAX_ENTRIES - 1)]));
    settle();
    set_table_size((1 << TS_W) - 1);
    send_ident(to_chars(entry_word[MAX_ENTRIES - 1]));
    send_ident(to_chars(entry_word[3]));
    settle();
  endtask

  // receiver stops for a long time while queries keep coming
  task automatic test_receiver_pressure();
    src_idle_pct = 0;
    @(posedge clk);
    hold_off_left = HOLD_OFF_CYCLES;
    @(negedge clk);
    repeat (6) send_ident(to_chars(entry_word[$urandom_range(0, MAX_ENTRIES - 1)]));
    settle();
    src_idle_pct = IDLE_PCT;
  endtask

  task automatic test_random_traffic();
    int done;
    int phase;
    int mode;
    int n;
    int stop;
    done  = 0;
    phase = 0;
    while (done < RANDOM_WORDS) begin
      // one phase runs with no idling on either side
      src_idle_pct  = (phase == 2) ? 0 : IDLE_PCT;
      sink_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
      mode = $urandom_range(0, 4);
      case (mode)
        0: n = 1;
        1: n = 2;
        2: n = $urandom_range(3, 40);
        3: n = $urandom_range(0, (1 << TS_W) - 1);
        default: n = MAX_ENTRIES;
      endcase
      if (mode <= 2) load_sorted_keys(n, 6);
      set_table_size(n);
      stop = words_sent + PHASE_WORDS;
      while (words_sent < stop) begin
        if ($urandom_range(0, 99) < 20) noise_load();
        else send_ident(random_ident());
      end
      done += PHASE_WORDS;
      settle();
      phase++;
    end
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
  endtask

  // receiver ready, with random stalls and the requested hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (lookups_due.size() == 0) begin
        $error("unexpected result word: found %0b match_index %0d",
               out_ch.found, out_ch.match_index);
        fails++;
      end else begin
        want = lookups_due.pop_front();
        if (out_ch.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_ch.found);
          fails++;
        end
        if (out_ch.match_index !== want.index) begin
          $error("match_index: expected %0d, got %0d", want.index, out_ch.match_index);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_LOAD;
    in_ch.entry_index   = '0;
    in_ch.char_position = '0;
    in_ch.char_value    = '0;
    in_ch.last_char     = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    table_size_r        = '0;
    ident_len           = 0;
    foreach (ident[i]) ident[i] = 8'h00;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_table();
    test_directed_cases();
    test_full_table();
    test_receiver_pressure();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d load words and %0d query words, %0d searches with %0d hits",
             load_words, query_words, searches, hits);
    $display("table sizes 0 to %0d, oversized tables, long and empty identifiers, hold-off",
             (1 << TS_W) - 1);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
